// ===== hdl/plm_pkg.sv =====
// Shared types, constants and helpers for the price level FIFO matcher.
// Used by plm_store and price_level_fifo_matcher; depends on nothing.
package plm_pkg;

   localparam int LEVEL_DEPTH = 16;
   localparam int PTR_W = $clog2(LEVEL_DEPTH);
   localparam int CNT_W = $clog2(LEVEL_DEPTH + 1);

   typedef struct packed {
      logic [31:0] id;
      logic [31:0] qty;
   } entry_type;

   typedef enum logic [1:0] {
      REQ_ADD    = 2'd0,
      REQ_CANCEL = 2'd1,
      REQ_MATCH  = 2'd2,
      REQ_NONE   = 2'd3
   } req_code_type;

   typedef enum logic [2:0] {
      KIND_ADDED     = 3'd0,
      KIND_FULL      = 3'd1,
      KIND_CANCELLED = 3'd2,
      KIND_NOT_FOUND = 3'd3,
      KIND_TRADE     = 3'd4,
      KIND_NO_TRADE  = 3'd5
   } kind_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_SHIFT,
      ST_MATCH,
      ST_OUT
   } state_type;

   // ring index: head plus an offset below LEVEL_DEPTH
   function automatic logic [PTR_W-1:0] ring_idx(input logic [PTR_W-1:0] head,
                                                 input logic [CNT_W-1:0] off);
      logic [PTR_W:0] s;
      s = {1'b0, head} + {1'b0, off[PTR_W-1:0]};
      if (s >= (PTR_W+1)'(LEVEL_DEPTH)) begin
         s = s - (PTR_W+1)'(LEVEL_DEPTH);
      end
      return s[PTR_W-1:0];
   endfunction

endpackage

// ===== hdl/plm_store.sv =====
// Order store: one synchronous memory of (id, qty) entries, registered read.
// Depends on plm_pkg.
module plm_store (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [plm_pkg::PTR_W-1:0]  wr_addr,
   input  plm_pkg::entry_type         wr_data,
   input  logic                       rd_en,
   input  logic [plm_pkg::PTR_W-1:0]  rd_addr,
   output plm_pkg::entry_type         rd_data
);
   import plm_pkg::*;

   entry_type mem [LEVEL_DEPTH];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/price_level_fifo_matcher.sv =====
// Top level of one order book price level with time-priority FIFO matching.
// Depends on plm_pkg and plm_store.
//
//   channel  direction  handshake               payload
//   req      in         req_valid / req_stall   req_type, req_order_id, req_order_qty
//   rsp      out        rsp_valid / rsp_stall   rsp_result_kind .. rsp_last
//   csr      in         csr_wr_en               csr_wr_data (level price)
//
// One item at a time. Add: the entry is written and one result given. Cancel:
// entries are searched one by one, then each later entry is moved down in turn.
// Match: each trade reads the head entry (registered store read), one result each.
// The order store's single read port forces this one-entry-at-a-time walk.
// Synchronous reset empties the level and clears the trade counter and price.
// A stalled result holds; no new item is taken until the last result leaves.
module price_level_fifo_matcher (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_type,
   input  logic [31:0] req_order_id,
   input  logic [31:0] req_order_qty,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_result_kind,
   output logic [31:0] rsp_trade_id,
   output logic [31:0] rsp_trade_price,
   output logic [31:0] rsp_trade_qty,
   output logic [31:0] rsp_incoming_id,
   output logic [31:0] rsp_resting_id,
   output logic        rsp_resting_filled,
   output logic [31:0] rsp_incoming_left,
   output logic [35:0] rsp_level_qty,
   output logic [4:0]  rsp_level_count,
   output logic        rsp_last,
   input  logic        csr_wr_en,
   input  logic [31:0] csr_wr_data
);
   import plm_pkg::*;

   state_type         state_ff, state_in;
   logic [PTR_W-1:0]  head_ff, head_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CNT_W-1:0]  k_ff, k_in;
   logic [35:0]       total_ff, total_in;
   logic [31:0]       tcnt_ff, tcnt_in;
   logic [31:0]       price_ff;
   logic [31:0]       id_ff, id_in;
   logic [31:0]       left_ff, left_in;

   kind_type          kind_ff, kind_in;
   logic [31:0]       tid_ff, tid_in;
   logic [31:0]       tprice_ff, tprice_in;
   logic [31:0]       tqty_ff, tqty_in;
   logic [31:0]       inc_id_ff, inc_id_in;
   logic [31:0]       rest_id_ff, rest_id_in;
   logic              filled_ff, filled_in;
   logic [31:0]       inc_left_ff, inc_left_in;
   logic [35:0]       lqty_ff, lqty_in;
   logic [4:0]        lcnt_ff, lcnt_in;
   logic              last_ff, last_in;

   logic              wr_en, rd_en, load_rsp;
   logic [PTR_W-1:0]  wr_addr, rd_addr;
   entry_type         wr_data, rd_data;
   logic [31:0]       tq;
   logic [CNT_W:0]    k1, k2;

   plm_store u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign k1 = {1'b0, k_ff} + (CNT_W+1)'(1);
   assign k2 = {1'b0, k_ff} + (CNT_W+1)'(2);
   assign tq = (left_ff < rd_data.qty) ? left_ff : rd_data.qty;

   always_comb begin
      state_in    = state_ff;
      head_in     = head_ff;
      count_in    = count_ff;
      k_in        = k_ff;
      total_in    = total_ff;
      tcnt_in     = tcnt_ff;
      id_in       = id_ff;
      left_in     = left_ff;
      kind_in     = kind_ff;
      tid_in      = tid_ff;
      tprice_in   = tprice_ff;
      tqty_in     = tqty_ff;
      inc_id_in   = inc_id_ff;
      rest_id_in  = rest_id_ff;
      filled_in   = filled_ff;
      inc_left_in = inc_left_ff;
      last_in     = last_ff;
      load_rsp    = 1'b0;
      wr_en       = 1'b0;
      wr_addr     = head_ff;
      wr_data     = rd_data;
      rd_en       = 1'b0;
      rd_addr     = head_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               id_in       = req_order_id;
               left_in     = req_order_qty;
               tid_in      = '0;
               tprice_in   = '0;
               tqty_in     = '0;
               inc_id_in   = '0;
               rest_id_in  = '0;
               filled_in   = 1'b0;
               inc_left_in = '0;
               last_in     = 1'b1;
               k_in        = '0;
               unique case (req_type)
                  REQ_ADD: begin
                     load_rsp = 1'b1;
                     state_in = ST_OUT;
                     if (count_ff == CNT_W'(LEVEL_DEPTH)) begin
                        kind_in = KIND_FULL;
                     end else begin
                        kind_in     = KIND_ADDED;
                        wr_en       = 1'b1;
                        wr_addr     = ring_idx(head_ff, count_ff);
                        wr_data.id  = req_order_id;
                        wr_data.qty = req_order_qty;
                        count_in    = count_ff + CNT_W'(1);
                        total_in    = total_ff + {4'd0, req_order_qty};
                     end
                  end
                  REQ_CANCEL: begin
                     if (count_ff == '0) begin
                        kind_in  = KIND_NOT_FOUND;
                        load_rsp = 1'b1;
                        state_in = ST_OUT;
                     end else begin
                        rd_en    = 1'b1;
                        state_in = ST_SEARCH;
                     end
                  end
                  REQ_MATCH: begin
                     if (count_ff == '0 || req_order_qty == '0) begin
                        kind_in     = KIND_NO_TRADE;
                        inc_id_in   = req_order_id;
                        inc_left_in = req_order_qty;
                        load_rsp    = 1'b1;
                        state_in    = ST_OUT;
                     end else begin
                        rd_en    = 1'b1;
                        state_in = ST_MATCH;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_SEARCH: begin
            // rd_data holds entry k
            if (rd_data.id == id_ff) begin
               total_in = total_ff - {4'd0, rd_data.qty};
               if (k1 < {1'b0, count_ff}) begin
                  rd_en    = 1'b1;
                  rd_addr  = ring_idx(head_ff, k1[CNT_W-1:0]);
                  state_in = ST_SHIFT;
               end else begin
                  count_in = count_ff - CNT_W'(1);
                  kind_in  = KIND_CANCELLED;
                  load_rsp = 1'b1;
                  state_in = ST_OUT;
               end
            end else if (k1 < {1'b0, count_ff}) begin
               k_in    = k1[CNT_W-1:0];
               rd_en   = 1'b1;
               rd_addr = ring_idx(head_ff, k1[CNT_W-1:0]);
            end else begin
               kind_in  = KIND_NOT_FOUND;
               load_rsp = 1'b1;
               state_in = ST_OUT;
            end
         end
         ST_SHIFT: begin
            // rd_data holds entry k+1; move it down to k
            wr_en   = 1'b1;
            wr_addr = ring_idx(head_ff, k_ff);
            if (k2 < {1'b0, count_ff}) begin
               k_in    = k1[CNT_W-1:0];
               rd_en   = 1'b1;
               rd_addr = ring_idx(head_ff, k2[CNT_W-1:0]);
            end else begin
               count_in = count_ff - CNT_W'(1);
               kind_in  = KIND_CANCELLED;
               load_rsp = 1'b1;
               state_in = ST_OUT;
            end
         end
         ST_MATCH: begin
            // rd_data holds the head entry
            tcnt_in     = tcnt_ff + 32'd1;
            left_in     = left_ff - tq;
            total_in    = total_ff - {4'd0, tq};
            kind_in     = KIND_TRADE;
            tid_in      = tcnt_ff + 32'd1;
            tprice_in   = price_ff;
            tqty_in     = tq;
            inc_id_in   = id_ff;
            rest_id_in  = rd_data.id;
            filled_in   = (tq == rd_data.qty);
            inc_left_in = left_ff - tq;
            if (tq == rd_data.qty) begin
               head_in  = ring_idx(head_ff, CNT_W'(1));
               count_in = count_ff - CNT_W'(1);
            end else begin
               wr_en       = 1'b1;
               wr_data.qty = rd_data.qty - tq;
            end
            last_in  = (count_in == '0) || (left_ff == tq);
            load_rsp = 1'b1;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (!rsp_stall) begin
               if (last_ff) begin
                  state_in = ST_IDLE;
               end else begin
                  rd_en    = 1'b1;
                  state_in = ST_MATCH;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase

      lqty_in = lqty_ff;
      lcnt_in = lcnt_ff;
      if (load_rsp) begin
         lqty_in = total_in;
         lcnt_in = 5'(count_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         head_ff  <= '0;
         count_ff <= '0;
         total_ff <= '0;
         tcnt_ff  <= '0;
         price_ff <= '0;
      end else begin
         state_ff <= state_in;
         head_ff  <= head_in;
         count_ff <= count_in;
         total_ff <= total_in;
         tcnt_ff  <= tcnt_in;
         if (csr_wr_en) begin
            price_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      k_ff        <= k_in;
      id_ff       <= id_in;
      left_ff     <= left_in;
      kind_ff     <= kind_in;
      tid_ff      <= tid_in;
      tprice_ff   <= tprice_in;
      tqty_ff     <= tqty_in;
      inc_id_ff   <= inc_id_in;
      rest_id_ff  <= rest_id_in;
      filled_ff   <= filled_in;
      inc_left_ff <= inc_left_in;
      lqty_ff     <= lqty_in;
      lcnt_ff     <= lcnt_in;
      last_ff     <= last_in;
   end

   assign req_stall          = (state_ff != ST_IDLE);
   assign rsp_valid          = (state_ff == ST_OUT);
   assign rsp_result_kind    = kind_ff;
   assign rsp_trade_id       = tid_ff;
   assign rsp_trade_price    = tprice_ff;
   assign rsp_trade_qty      = tqty_ff;
   assign rsp_incoming_id    = inc_id_ff;
   assign rsp_resting_id     = rest_id_ff;
   assign rsp_resting_filled = filled_ff;
   assign rsp_incoming_left  = inc_left_ff;
   assign rsp_level_qty      = lqty_ff;
   assign rsp_level_count    = lcnt_ff;
   assign rsp_last           = last_ff;

`ifndef NO_ASSERTIONS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(LEVEL_DEPTH))
      else $error("order count beyond store depth");

   a_nontrade_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_result_kind != KIND_TRADE |-> rsp_last)
      else $error("non-trade result not marked last");

   a_trade_follows: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_last |=> ##1 rsp_valid && rsp_result_kind == KIND_TRADE)
      else $error("missing follow-on trade");

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("input taken while result pending");
`endif

endmodule

// ===== verif/testbench.sv =====
// Self-checking testbench for price_level_fifo_matcher: random and directed add,
// cancel and match items, with results predicted in-line and checked in order.
// Depends on plm_pkg and the price_level_fifo_matcher RTL.
`timescale 1ns / 1ps

module testbench;
   import plm_pkg::*;

   typedef enum logic [1:0] {OP_ITEM, OP_CFG, OP_DRAIN} step_kind_type;

   typedef struct {
      step_kind_type step;
      req_code_type  rtype;
      logic [31:0]   id;
      logic [31:0]   qty;
      logic          quiet;
   } step_type;

   typedef struct {
      kind_type    kind;
      logic [31:0] trade_id;
      logic [31:0] trade_price;
      logic [31:0] fill_qty;
      logic [31:0] incoming_id;
      logic [31:0] resting_id;
      logic        resting_filled;
      logic [31:0] incoming_left;
      logic [35:0] level_qty;
      logic [4:0]  level_count;
      logic        last;
   } fill_type;

   localparam int SETTLE_CYCLES = 40;
   localparam int WATCHDOG_LIMIT = 4000;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_stall;
   logic [1:0]  req_type = 0;
   logic [31:0] req_order_id = 0;
   logic [31:0] req_order_qty = 0;
   logic        rsp_valid;
   logic        rsp_stall = 0;
   logic [2:0]  rsp_result_kind;
   logic [31:0] rsp_trade_id, rsp_trade_price, rsp_trade_qty;
   logic [31:0] rsp_incoming_id, rsp_resting_id, rsp_incoming_left;
   logic        rsp_resting_filled, rsp_last;
   logic [35:0] rsp_level_qty;
   logic [4:0]  rsp_level_count;
   logic        csr_wr_en = 0;
   logic [31:0] csr_wr_data = 0;

   price_level_fifo_matcher uut (.*);

   always #10 clock = ~clock;

   step_type    pending_steps[$];
   fill_type    expected_fills[$];
   int          errors = 0;
   logic        quiet_phase = 0;

   // book image
   logic [31:0] book_ids[LEVEL_DEPTH];
   logic [31:0] book_qtys[LEVEL_DEPTH];
   int          book_count = 0;
   logic [35:0] book_total = 0;
   logic [31:0] trade_seq = 0;
   logic [31:0] price = 0;

   function automatic fill_type plain_fill(kind_type k);
      fill_type f;
      f = '{kind: k, default: 0};
      f.level_qty = book_total;
      f.level_count = 5'(book_count);
      f.last = 1;
      return f;
   endfunction

   function automatic void expect_fill(fill_type f);
      expected_fills = {expected_fills, f};
   endfunction

   function automatic void drop_book_entry(int pos);
      for (int i = pos; i + 1 < book_count; i++) begin
         book_ids[i] = book_ids[i+1];
         book_qtys[i] = book_qtys[i+1];
      end
      book_count--;
   endfunction

   function automatic void book_apply(req_code_type rt, logic [31:0] id, logic [31:0] qty);
      fill_type    f;
      logic [31:0] left, tq;
      int          n;
      bit          hit;
      case (rt)
         REQ_ADD: begin
            if (book_count >= LEVEL_DEPTH) begin
               expect_fill(plain_fill(KIND_FULL));
            end else begin
               book_ids[book_count] = id;
               book_qtys[book_count] = qty;
               book_count++;
               book_total = book_total + 36'(qty);
               expect_fill(plain_fill(KIND_ADDED));
            end
         end
         REQ_CANCEL: begin
            hit = 0;
            for (int i = 0; i < book_count && !hit; i++) begin
               if (book_ids[i] == id) begin
                  book_total = book_total - 36'(book_qtys[i]);
                  drop_book_entry(i);
                  hit = 1;
               end
            end
            expect_fill(plain_fill(hit ? KIND_CANCELLED : KIND_NOT_FOUND));
         end
         REQ_MATCH: begin
            left = qty;
            if (book_count == 0 || left == 0) begin
               f = plain_fill(KIND_NO_TRADE);
               f.incoming_id = id;
               f.incoming_left = left;
               expect_fill(f);
            end else begin
               n = 0;
               while (book_count > 0 && left > 0 && n < LEVEL_DEPTH) begin
                  f = plain_fill(KIND_TRADE);
                  trade_seq = trade_seq + 1;
                  tq = (left < book_qtys[0]) ? left : book_qtys[0];
                  left = left - tq;
                  book_qtys[0] = book_qtys[0] - tq;
                  book_total = book_total - 36'(tq);
                  f.resting_id = book_ids[0];
                  f.resting_filled = (book_qtys[0] == 0);
                  if (f.resting_filled) drop_book_entry(0);
                  f.trade_id = trade_seq;
                  f.trade_price = price;
                  f.fill_qty = tq;
                  f.incoming_id = id;
                  f.incoming_left = left;
                  f.level_qty = book_total;
                  f.level_count = 5'(book_count);
                  f.last = (book_count == 0 || left == 0);
                  expect_fill(f);
                  n++;
               end
            end
         end
         default: ;
      endcase
   endfunction

   // driver
   int settle = 0;
   always @(posedge clock) begin
      step_type s;
      logic     nv;
      logic     wr;
      nv = req_valid;
      wr = 0;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            book_apply(req_code_type'(req_type), req_order_id, req_order_qty);
            nv = 0;
         end
         if (expected_fills.size() == 0 && !req_valid) settle <= settle + 1;
         else settle <= 0;
         if (!nv && pending_steps.size() > 0) begin
            s = pending_steps[0];
            quiet_phase <= s.quiet;
            if (s.step != OP_ITEM) begin
               if (settle >= SETTLE_CYCLES && !req_valid) begin
                  if (s.step == OP_CFG) begin
                     wr = 1;
                     csr_wr_data <= s.qty;
                     price = s.qty;
                  end
                  pending_steps.delete(0);
               end
            end else if (s.quiet || $urandom_range(99) >= 24) begin
               req_type <= s.rtype;
               req_order_id <= s.id;
               req_order_qty <= s.qty;
               nv = 1;
               pending_steps.delete(0);
            end
         end
      end
      req_valid <= nv;
      csr_wr_en <= wr;
   end

   function automatic void check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
      if (exp_v !== act_v) begin
         $error("%s: expected %0h, got %0h", name, exp_v, act_v);
         errors++;
      end
   endfunction

   // monitor
   always @(posedge clock) begin
      fill_type f;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_fills.size() == 0) begin
            $error("result_kind: expected none, got %0d", rsp_result_kind);
            errors++;
         end else begin
            f = expected_fills[0];
            expected_fills.delete(0);
            check_field("result_kind", f.kind, rsp_result_kind);
            check_field("trade_id", f.trade_id, rsp_trade_id);
            check_field("trade_price", f.trade_price, rsp_trade_price);
            check_field("trade_qty", f.fill_qty, rsp_trade_qty);
            check_field("incoming_id", f.incoming_id, rsp_incoming_id);
            check_field("resting_id", f.resting_id, rsp_resting_id);
            check_field("resting_filled", f.resting_filled, rsp_resting_filled);
            check_field("incoming_left", f.incoming_left, rsp_incoming_left);
            check_field("level_qty", f.level_qty, rsp_level_qty);
            check_field("level_count", f.level_count, rsp_level_count);
            check_field("last", f.last, rsp_last);
         end
      end
      rsp_stall <= reset ? 1'b0 : (!quiet_phase && $urandom_range(99) < 24);
   end

   // watchdog on cycles without any handshake
   int stuck = 0;
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) stuck <= 0;
      else stuck <= stuck + 1;
      if (stuck >= WATCHDOG_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   function automatic void add_item(req_code_type rt, logic [31:0] id, logic [31:0] qty,
                                    logic quiet = 0);
      pending_steps = {pending_steps, step_type'{OP_ITEM, rt, id, qty, quiet}};
   endfunction

   function automatic void add_step(step_kind_type k, logic [31:0] val = 0);
      pending_steps = {pending_steps, step_type'{k, REQ_NONE, 32'd0, val, 1'b0}};
   endfunction

   function automatic logic [31:0] pick_qty();
      case ($urandom_range(9))
         0: return 0;
         1: return 32'hFFFF_FFFF;
         2: return $urandom;
         default: return $urandom_range(1, 20);
      endcase
   endfunction

   function automatic logic [31:0] pick_id();
      return ($urandom_range(9) == 0) ? $urandom : $urandom_range(0, 7);
   endfunction

   initial begin
      int r;
      logic q;
      // directed
      add_step(OP_CFG, 32'hFFFF_FFFF);
      add_item(REQ_MATCH, 32'h1111, 5);
      add_item(REQ_ADD, 0, 0);
      add_item(REQ_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      add_item(REQ_ADD, 32'hFFFF_FFFF, 7);
      add_item(REQ_MATCH, 32'hAAAA_5555, 0);
      add_item(REQ_CANCEL, 32'h1234_5678, 0);
      add_item(REQ_CANCEL, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      add_item(REQ_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      add_item(REQ_MATCH, 32'h5555_AAAA, 32'hFFFF_FFFF);
      for (int i = 0; i < 17; i++) add_item(REQ_ADD, i, 1);
      add_item(REQ_MATCH, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      add_step(OP_CFG, 0);
      // random phases with price changes between them
      for (int ph = 0; ph < 6; ph++) begin
         case (ph)
            2: add_step(OP_CFG, 32'hFFFF_FFFF);
            4: add_step(OP_CFG, 0);
            default: add_step(OP_CFG, $urandom);
         endcase
         for (int i = 0; i < 70; i++) begin
            q = (ph == 3);
            if (ph == 1 && i == 35) add_step(OP_DRAIN);
            r = $urandom_range(99);
            if (r < 45) add_item(REQ_ADD, pick_id(), pick_qty(), q);
            else if (r < 65) add_item(REQ_CANCEL, pick_id(), $urandom, q);
            else if (r < 95) add_item(REQ_MATCH, $urandom, pick_qty(), q);
            else add_item(REQ_NONE, $urandom, $urandom, q);
         end
      end
      repeat (10) @(posedge clock);
      reset <= 0;
      while (pending_steps.size() != 0 || req_valid || expected_fills.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (errors == 0 && expected_fills.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
